// File: hw/rtl/u8u16_pkg.sv
// shared types, constants and byte classing for the utf-8 to utf-16 transcoder
package u8u16_pkg;

  localparam int unsigned MaxUnits = 4;

  localparam logic [15:0] UNIT_BAD  = 16'h003F;
  localparam logic [15:0] HIGH_SURR = 16'hD800;
  localparam logic [15:0] LOW_SURR  = 16'hDC00;
  localparam logic [20:0] PLANE_ONE = 21'h10000;

  typedef enum logic [2:0] {
    KIND_CONT,
    KIND_SINGLE,
    KIND_LEAD2,
    KIND_LEAD3,
    KIND_LEAD4,
    KIND_BAD
  } byte_kind_t;

  // units produced by one input byte, lowest slot goes out first
  typedef struct packed {
    logic [MaxUnits-1:0][15:0] units;
    logic [2:0]                count;
    logic                      last;
  } unit_bundle_t;

  // class a byte by its top five bits
  function automatic byte_kind_t kind_of(input logic [7:0] b);
    byte_kind_t k;
    priority if (b[7] == 1'b0) begin
      k = KIND_SINGLE;
    end else if (b[7:6] == 2'b10) begin
      k = KIND_CONT;
    end else if (b[7:5] == 3'b110) begin
      k = KIND_LEAD2;
    end else if (b[7:4] == 4'b1110) begin
      k = KIND_LEAD3;
    end else if (b[7:3] == 5'b11110) begin
      k = KIND_LEAD4;
    end else begin
      k = KIND_BAD;
    end
    return k;
  endfunction

endpackage

// File: hw/rtl/u8u16_step.sv
// per-byte decode step with the open-sequence state registers
module u8u16_step (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    take,
  input  logic [7:0]              in_byte,
  input  logic                    is_last,
  output u8u16_pkg::unit_bundle_t bundle
);

  logic [1:0]  bytes_needed, bytes_needed_next;
  logic [1:0]  bytes_taken, bytes_taken_next;
  logic [20:0] partial_point, partial_point_next;

  u8u16_pkg::byte_kind_t kind;
  logic        open_seq;
  logic [2:0]  pre_bad;
  logic [15:0] fresh_unit;
  logic [2:0]  fresh_cnt;
  logic [20:0] grown;
  logic [20:0] offset;
  logic [1:0]  taken_inc;

  assign kind      = u8u16_pkg::kind_of(in_byte);
  assign open_seq  = (bytes_needed != 2'd0);
  assign grown     = {partial_point[14:0], in_byte[5:0]};
  assign offset    = grown - u8u16_pkg::PLANE_ONE;
  assign taken_inc = bytes_taken + 2'd1;

  always_comb begin
    bytes_needed_next  = bytes_needed;
    bytes_taken_next   = bytes_taken;
    partial_point_next = partial_point;
    bundle.last        = is_last;
    bundle.count       = 3'd0;
    bundle.units       = '{default: u8u16_pkg::UNIT_BAD};
    pre_bad            = 3'd0;
    fresh_unit         = u8u16_pkg::UNIT_BAD;
    fresh_cnt          = 3'd1;

    if (open_seq && kind == u8u16_pkg::KIND_CONT) begin
      // continuation extends the open sequence
      if (taken_inc == bytes_needed) begin
        if (grown[20:16] == 5'd0) begin
          bundle.units[0] = grown[15:0];
          bundle.count    = 3'd1;
        end else begin
          bundle.units[0] = u8u16_pkg::HIGH_SURR + {5'd0, offset[20:10]};
          bundle.units[1] = u8u16_pkg::LOW_SURR + {6'd0, offset[9:0]};
          bundle.count    = 3'd2;
        end
        bytes_needed_next  = 2'd0;
        bytes_taken_next   = 2'd0;
        partial_point_next = '0;
      end else if (is_last) begin
        // cut off by end of string: lead plus taken bytes become '?'
        bundle.count       = {1'b0, taken_inc} + 3'd1;
        bytes_needed_next  = 2'd0;
        bytes_taken_next   = 2'd0;
        partial_point_next = '0;
      end else begin
        bytes_taken_next   = taken_inc;
        partial_point_next = grown;
      end
    end else begin
      // broken sequence flushes first, then the byte starts fresh
      if (open_seq) begin
        pre_bad = {1'b0, bytes_taken} + 3'd1;
      end
      bytes_needed_next  = 2'd0;
      bytes_taken_next   = 2'd0;
      partial_point_next = '0;
      unique case (kind)
        u8u16_pkg::KIND_SINGLE: begin
          fresh_unit = {8'd0, in_byte};
        end
        u8u16_pkg::KIND_CONT, u8u16_pkg::KIND_BAD: begin
          fresh_unit = u8u16_pkg::UNIT_BAD;
        end
        u8u16_pkg::KIND_LEAD2, u8u16_pkg::KIND_LEAD3, u8u16_pkg::KIND_LEAD4: begin
          if (is_last) begin
            fresh_unit = u8u16_pkg::UNIT_BAD;
          end else begin
            fresh_cnt = 3'd0;
            unique case (kind)
              u8u16_pkg::KIND_LEAD2: begin
                bytes_needed_next  = 2'd1;
                partial_point_next = {16'd0, in_byte[4:0]};
              end
              u8u16_pkg::KIND_LEAD3: begin
                bytes_needed_next  = 2'd2;
                partial_point_next = {17'd0, in_byte[3:0]};
              end
              default: begin
                bytes_needed_next  = 2'd3;
                partial_point_next = {18'd0, in_byte[2:0]};
              end
            endcase
          end
        end
        default: begin
          fresh_unit = u8u16_pkg::UNIT_BAD;
        end
      endcase
      for (int i = 0; i < u8u16_pkg::MaxUnits; i++) begin
        if (3'(i) >= pre_bad) begin
          bundle.units[i] = fresh_unit;
        end
      end
      bundle.count = pre_bad + fresh_cnt;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_needed  <= 2'd0;
      bytes_taken   <= 2'd0;
      partial_point <= '0;
    end else if (take) begin
      bytes_needed  <= bytes_needed_next;
      bytes_taken   <= bytes_taken_next;
      partial_point <= partial_point_next;
    end
  end

endmodule

// File: hw/rtl/u8u16_unit_queue.sv
// result register that hands out the units of one byte one per cycle while unit_ready is high
module u8u16_unit_queue (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    load,
  input  u8u16_pkg::unit_bundle_t bundle,
  output logic                    can_load,
  output logic                    unit_valid,
  input  logic                    unit_ready,
  output logic [15:0]             code_unit,
  output logic                    last_unit
);

  logic [u8u16_pkg::MaxUnits-1:0][15:0] units;
  logic [2:0] remaining;
  logic [1:0] slot;
  logic       bundle_last;
  logic       pop;

  assign unit_valid = (remaining != 3'd0);
  assign pop        = unit_valid && unit_ready;
  assign can_load   = (remaining == 3'd0) || (remaining == 3'd1 && unit_ready);
  assign code_unit  = units[slot];
  assign last_unit  = bundle_last && (remaining == 3'd1);

  always_ff @(posedge clk) begin
    if (rst) begin
      remaining <= 3'd0;
      slot      <= 2'd0;
    end else if (load) begin
      remaining <= bundle.count;
      slot      <= 2'd0;
    end else if (pop) begin
      remaining <= remaining - 3'd1;
      slot      <= slot + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      units       <= bundle.units;
      bundle_last <= bundle.last;
    end
  end

endmodule

// File: hw/rtl/utf8_to_utf16_transcoder.sv
// top level: utf-8 byte stream in, utf-16 code unit stream out
//
// Takes one utf-8 byte per request with tlast on the final byte of a string
// and gives utf-16 code units, tlast on the final unit of that string. A byte
// sits in an input register while the decode step classes it, extends or
// closes the open sequence and forms zero to four units; these are caught in
// a result register and leave one unit per cycle while the unit side is
// ready. A byte is taken every cycle as long as each byte gives at most one
// unit and the unit side is ready; a byte that gives more units holds the
// stream until all of them have left. Bad leads, stray continuations, broken and
// cut-off sequences turn into one '?' for the lead and for each continuation
// taken; the breaking byte is then decoded on its own. Overlong forms and
// encoded surrogates pass unchecked.
module utf8_to_utf16_transcoder (
  input  logic        clk,
  input  logic        rst,
  // byte side
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
  input  logic        s_axis_tlast,   // is_last
  // unit side
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [15:0] code_unit
  output logic        m_axis_tlast    // last_unit
);

  // input register
  logic       in_valid;
  logic [7:0] in_byte;
  logic       is_last;

  logic                    can_load;
  logic                    advance;
  logic                    s_take;
  u8u16_pkg::unit_bundle_t bundle;

  // the held byte moves on when the result register is free or frees up now
  assign advance       = in_valid && can_load;
  assign s_axis_tready = !in_valid || advance;
  assign s_take        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_take) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_take) begin
      in_byte <= s_axis_tdata;
      is_last <= s_axis_tlast;
    end
  end

  // decode step and sequence state
  u8u16_step u_step (
    .clk     (clk),
    .rst     (rst),
    .take    (advance),
    .in_byte (in_byte),
    .is_last (is_last),
    .bundle  (bundle)
  );

  // result register, one unit per cycle out while m_axis_tready is high
  u8u16_unit_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .load       (advance),
    .bundle     (bundle),
    .can_load   (can_load),
    .unit_valid (m_axis_tvalid),
    .unit_ready (m_axis_tready),
    .code_unit  (m_axis_tdata),
    .last_unit  (m_axis_tlast)
  );

endmodule

// File: verif/tb.sv
// self-checking testbench for the utf-8 to utf-16 transcoder
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import u8u16_pkg::*;

  // cycles with no request moving on either side before the run is called hung
  localparam int StallLimit = 2000;
  // cycles to linger after the last unit
  localparam int DrainCycles = 8;

  typedef logic [7:0] byte_q_t [$];

  // one expected request on the unit side
  typedef struct packed {
    logic [15:0] code_unit;
    logic        last_unit;
  } unit_req_t;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;   // [7:0] in_byte
  logic        s_axis_tlast;   // is_last
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;   // [15:0] code_unit
  logic        m_axis_tlast;   // last_unit

  // decoder state mirrored from the byte stream
  logic [1:0]  seq_need;
  logic [1:0]  seq_taken;
  logic [20:0] seq_value;

  unit_req_t   expected_unit_reqs [$];
  logic [15:0] units_of_byte [$];

  int errors;
  int bytes_sent;
  int send_idle_pct;
  int recv_stall_pct;

  utf8_to_utf16_transcoder u_dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // unit predictor
  // ---------------------------------------------------------------------------

  // byte class from the top five bits
  function automatic byte_kind_t classify_byte(input logic [7:0] b);
    casez (b[7:3])
      5'b0????: return KIND_SINGLE;
      5'b10???: return KIND_CONT;
      5'b110??: return KIND_LEAD2;
      5'b1110?: return KIND_LEAD3;
      5'b11110: return KIND_LEAD4;
      default:  return KIND_BAD;
    endcase
  endfunction

  // a byte never gives more than four units
  function automatic void add_unit(input logic [15:0] u);
    if (units_of_byte.size() < MaxUnits) units_of_byte.push_back(u);
  endfunction

  // one unit below plane one, else a surrogate pair
  function automatic void add_code_point(input logic [20:0] cp);
    logic [20:0] offs;
    if (cp < PLANE_ONE) begin
      add_unit(cp[15:0]);
    end else begin
      offs = cp - PLANE_ONE;
      add_unit(HIGH_SURR + {5'd0, offs[20:10]});
      add_unit(LOW_SURR + {6'd0, offs[9:0]});
    end
  endfunction

  // abandon the open sequence: one '?' for the lead and each continuation
  function automatic void abandon_sequence();
    for (int k = 0; k <= int'(seq_taken); k++) add_unit(UNIT_BAD);
    seq_need  = '0;
    seq_taken = '0;
    seq_value = '0;
  endfunction

  // advance the mirrored decoder by one byte, queue the units it gives
  function automatic void predict_units(input logic [7:0] b, input logic is_last);
    byte_kind_t kind;
    bit         fresh;
    kind  = classify_byte(b);
    fresh = 1'b1;
    units_of_byte.delete();

    if (seq_need != 2'd0) begin
      if (kind == KIND_CONT) begin
        fresh     = 1'b0;
        seq_value = {seq_value[14:0], b[5:0]};
        seq_taken = seq_taken + 2'd1;
        if (seq_taken == seq_need) begin
          add_code_point(seq_value);
          seq_need  = '0;
          seq_taken = '0;
          seq_value = '0;
        end else if (is_last) begin
          // sequence cut off by the end of the string
          abandon_sequence();
        end
      end else begin
        // break in a sequence, the breaking byte is decoded on its own below
        abandon_sequence();
      end
    end

    if (fresh) begin
      case (kind)
        KIND_SINGLE: add_unit({8'd0, b});
        KIND_CONT, KIND_BAD: add_unit(UNIT_BAD);
        default: begin
          seq_taken = '0;
          case (kind)
            KIND_LEAD2: begin
              seq_need  = 2'd1;
              seq_value = {16'd0, b[4:0]};
            end
            KIND_LEAD3: begin
              seq_need  = 2'd2;
              seq_value = {17'd0, b[3:0]};
            end
            default: begin
              seq_need  = 2'd3;
              seq_value = {18'd0, b[2:0]};
            end
          endcase
          // lead on the final byte
          if (is_last) abandon_sequence();
        end
      endcase
    end

    foreach (units_of_byte[i]) begin
      expected_unit_reqs.push_back('{units_of_byte[i],
                                     is_last && (i == units_of_byte.size() - 1)});
    end
  endfunction

  // ---------------------------------------------------------------------------
  // monitor and checker, sampled at the rising edge
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : check_units
    unit_req_t head;
    if (!rst) begin
      // predict first so a unit is never checked ahead of its own byte
      if (s_axis_tvalid && s_axis_tready) predict_units(s_axis_tdata, s_axis_tlast);
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_unit_reqs.size() == 0) begin
          $error("unit request with none expected: code_unit %h last_unit %b",
                 m_axis_tdata, m_axis_tlast);
          errors++;
        end else begin
          head = expected_unit_reqs.pop_front();
          if (m_axis_tdata !== head.code_unit) begin
            $error("code_unit expected %h actual %h", head.code_unit, m_axis_tdata);
            errors++;
          end
          if (m_axis_tlast !== head.last_unit) begin
            $error("last_unit expected %b actual %b", head.last_unit, m_axis_tlast);
            errors++;
          end
        end
      end
    end
  end

  // hang detector: nothing moving on either side for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < StallLimit) begin
      @(posedge clk);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        quiet = 0;
      else
        quiet++;
    end
    $display("FAIL utf8_to_utf16_transcoder");
    $finish;
  end

  // unit side backpressure, redrawn every cycle
  always @(negedge clk) begin
    m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // ---------------------------------------------------------------------------
  // byte side driver
  // ---------------------------------------------------------------------------

  // present one byte request after a random gap and hold it until taken
  task automatic send_byte(input logic [7:0] b, input logic is_last);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= is_last;
    do @(posedge clk); while (!s_axis_tready);
    bytes_sent++;
  endtask

  task automatic send_string(input byte_q_t s, input bit end_last);
    foreach (s[i]) send_byte(s[i], end_last && (i == s.size() - 1));
  endtask

  // one sequence of the given length with random payload bits, optionally cut short
  task automatic send_sequence(input int len, input bit cut, input bit end_last);
    logic [7:0] lead;
    int         n;
    lead = 8'($urandom);
    case (len)
      1:       lead = {1'b0, lead[6:0]};
      2:       lead = {3'b110, lead[4:0]};
      3:       lead = {4'b1110, lead[3:0]};
      default: lead = {5'b11110, lead[2:0]};
    endcase
    n = (cut && len > 1) ? $urandom_range(1, len - 1) : len;
    for (int i = 0; i < n; i++) begin
      if (i == 0) send_byte(lead, end_last && (n == 1));
      else send_byte({2'b10, 6'($urandom)}, end_last && (i == n - 1));
    end
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  task automatic test_single_bytes();
    send_string('{8'h00, 8'h7F}, 1'b1);
  endtask

  // two-byte, a surrogate pair, and a lead above the unicode range
  task automatic test_multibyte_sequences();
    send_string('{8'hC2, 8'hA9, 8'hF0, 8'h9F, 8'h98, 8'h80,
                  8'hF7, 8'hBF, 8'hBF, 8'hBF}, 1'b1);
  endtask

  // bad leads and a stray continuation, last on the stray one
  task automatic test_invalid_bytes();
    send_string('{8'hF8, 8'hFF, 8'h80}, 1'b1);
  endtask

  // a sequence broken by a single byte, another broken by a lead that then completes
  task automatic test_broken_sequences();
    send_string('{8'hE2, 8'h82, 8'h41, 8'hF0, 8'h9F, 8'hC2, 8'hA9}, 1'b1);
  endtask

  // cut off after a continuation, then a break whose new lead is itself cut off
  task automatic test_cut_off_sequences();
    send_string('{8'hE2, 8'h82}, 1'b1);
    send_string('{8'hF0, 8'h9F, 8'h98, 8'hF4}, 1'b1);
  endtask

  // mostly well-formed strings, with noise bytes and truncated sequences mixed in
  task automatic test_random_traffic(input int idle_pct, input int stall_pct, input int count);
    int stop_at;
    int pick;
    bit end_last;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    stop_at        = bytes_sent + count;
    while (bytes_sent < stop_at) begin
      pick     = $urandom_range(0, 99);
      end_last = ($urandom_range(0, 5) == 0);
      if (pick < 15) send_byte(8'($urandom), end_last);
      else if (pick < 25) send_sequence($urandom_range(2, 4), 1'b1, end_last);
      else send_sequence($urandom_range(1, 4), 1'b0, end_last);
    end
  endtask

  // ---------------------------------------------------------------------------
  // run
  // ---------------------------------------------------------------------------
  initial begin
    rst            = 1'b1;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    s_axis_tlast   = 1'b0;
    m_axis_tready  = 1'b0;
    seq_need       = '0;
    seq_taken      = '0;
    seq_value      = '0;
    errors         = 0;
    bytes_sent     = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_single_bytes();
    test_multibyte_sequences();
    test_invalid_bytes();
    test_broken_sequences();
    test_cut_off_sequences();

    test_random_traffic(0, 0, 70);
    test_random_traffic(78, 0, 70);
    test_random_traffic(0, 78, 70);
    test_random_traffic(8, 8, 70);

    // drop valid, then let every predicted unit come out
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    wait (expected_unit_reqs.size() == 0);
    repeat (DrainCycles) @(posedge clk);

    if (errors == 0 && expected_unit_reqs.size() == 0)
      $display("PASS utf8_to_utf16_transcoder");
    else
      $display("FAIL utf8_to_utf16_transcoder");
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/u8u16_pkg.sv
hw/rtl/u8u16_step.sv
hw/rtl/u8u16_unit_queue.sv
hw/rtl/utf8_to_utf16_transcoder.sv
verif/tb.sv
